### design/srsu_pkg.sv
package srsu_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_OFFSET = 2'd2;

  // Initial left and top bounding box edges.
  localparam logic signed [15:0] EDGE_INIT_LT = 16'sd1000;

  localparam logic [15:0] LEN_LIMIT = 16'hFFFF;

  // Write source select for the span table.
  localparam logic [1:0] WR_APPEND = 2'd0;
  localparam logic [1:0] WR_MOVE   = 2'd1;
  localparam logic [1:0] WR_BACK   = 2'd2;
  localparam logic [1:0] WR_SHIFT  = 2'd3;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] len;
  } entry_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] x;
    logic [15:0] len;
  } merge_t;

  typedef struct packed {
    logic       latch_in;
    logic       box_add;
    logic       box_ofs;
    logic       idx_inc;
    logic       mem_rd;
    logic       rd_last;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       cur_new;
    logic       cur_fold;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       inside_set;
    logic       drop_set;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_end;
    logic       not_last;
    logic       full;
    logic       box_ok;
    logic       hit_new;
    logic       hit_fold;
    logic       hit_query;
    logic       out_free;
  } stat_t;

  // Widen stored span [sx, sx+sl) by [nx, nx+nl) when they overlap or touch and the new span reaches past an end.
  function automatic merge_t span_merge(input logic [15:0] sx, input logic [15:0] sl,
                                        input logic [15:0] nx, input logic [15:0] nl);
    logic signed [17:0] s_l;
    logic signed [17:0] s_r;
    logic signed [17:0] n_l;
    logic signed [17:0] n_r;
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic signed [18:0] len;
    merge_t m;
    s_l = {{2{sx[15]}}, sx};
    s_r = s_l + {2'b00, sl};
    n_l = {{2{nx[15]}}, nx};
    n_r = n_l + {2'b00, nl};
    lo = s_l;
    hi = s_r;
    m.hit = 1'b0;
    if (n_l < s_l && n_r >= s_l) begin
      lo = n_l;
      m.hit = 1'b1;
    end
    if (n_l <= s_r && n_r > s_r) begin
      hi = n_r;
      m.hit = 1'b1;
    end
    len = {hi[17], hi} - {lo[17], lo};
    m.x = lo[15:0];
    m.len = (len > 19'sd65535) ? LEN_LIMIT : len[15:0];
    return m;
  endfunction

endpackage

### design/srsu_ctrl.sv
module srsu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  srsu_pkg::stat_t st,
  output srsu_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_EV  = 4'd3;
  localparam logic [3:0] S_A_APP = 4'd4;
  localparam logic [3:0] S_F_RD  = 4'd5;
  localparam logic [3:0] S_F_EV  = 4'd6;
  localparam logic [3:0] S_F_LRD = 4'd7;
  localparam logic [3:0] S_F_MV  = 4'd8;
  localparam logic [3:0] S_F_WB  = 4'd9;
  localparam logic [3:0] S_Q_RD  = 4'd10;
  localparam logic [3:0] S_Q_EV  = 4'd11;
  localparam logic [3:0] S_O_RD  = 4'd12;
  localparam logic [3:0] S_O_EV  = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (st.op == srsu_pkg::OP_ADD) begin
          cmd.box_add = 1'b1;
          state_nxt = S_A_RD;
        end else if (st.op == srsu_pkg::OP_QUERY) begin
          state_nxt = st.box_ok ? S_Q_RD : S_FIN;
        end else if (st.op == srsu_pkg::OP_OFFSET) begin
          cmd.box_ofs = 1'b1;
          state_nxt = S_O_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_A_RD: begin
        if (st.idx_end) begin
          state_nxt = S_A_APP;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd.idx_inc = 1'b1;
        if (st.hit_new) begin
          cmd.cur_new = 1'b1;
          state_nxt = S_F_RD;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_APP: begin
        if (st.full) begin
          cmd.drop_set = 1'b1;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = srsu_pkg::WR_APPEND;
          cmd.cnt_inc = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_F_RD: begin
        if (st.idx_end) begin
          state_nxt = S_F_WB;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt = S_F_EV;
        end
      end
      S_F_EV: begin
        if (st.hit_fold) begin
          cmd.cur_fold = 1'b1;
          if (st.not_last) begin
            state_nxt = S_F_LRD;
          end else begin
            cmd.cnt_dec = 1'b1;
            state_nxt = S_F_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_F_RD;
        end
      end
      S_F_LRD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_last = 1'b1;
        state_nxt = S_F_MV;
      end
      S_F_MV: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = srsu_pkg::WR_MOVE;
        cmd.cnt_dec = 1'b1;
        state_nxt = S_F_RD;
      end
      S_F_WB: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = srsu_pkg::WR_BACK;
        state_nxt = S_FIN;
      end
      S_Q_RD: begin
        if (st.idx_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt = S_Q_EV;
        end
      end
      S_Q_EV: begin
        cmd.idx_inc = 1'b1;
        if (st.hit_query) begin
          cmd.inside_set = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_Q_RD;
        end
      end
      S_O_RD: begin
        if (st.idx_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt = S_O_EV;
        end
      end
      S_O_EV: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = srsu_pkg::WR_SHIFT;
        cmd.idx_inc = 1'b1;
        state_nxt = S_O_RD;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/srsu_datapath.sv
module srsu_datapath #(
  parameter int MAX_SPANS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [47:0]    in_tdata,
  input  logic [1:0]     in_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [79:0]    out_tdata,
  input  srsu_pkg::cmd_t  cmd,
  output srsu_pkg::stat_t st
);

  localparam int AW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CW = $clog2(MAX_SPANS + 1);

  srsu_pkg::entry_t mem [MAX_SPANS];
  srsu_pkg::entry_t rdata_r;

  logic [1:0]  op_r;
  logic [15:0] in_x_r;
  logic [15:0] in_y_r;
  logic [14:0] in_len_r;

  logic [CW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] base_r;
  logic [15:0]   cur_x_r;
  logic [15:0]   cur_len_r;

  logic signed [15:0] left_r;
  logic signed [15:0] top_r;
  logic signed [16:0] right_r;
  logic signed [15:0] bottom_r;

  logic inside_r;
  logic drop_r;
  logic out_valid_r;
  logic [79:0] out_data_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  srsu_pkg::entry_t wdata;
  srsu_pkg::merge_t m_new;
  srsu_pkg::merge_t m_fold;
  logic signed [16:0] qx;
  logic signed [16:0] qy;
  logic signed [17:0] qx18;
  logic signed [17:0] ex18;
  logic signed [17:0] er18;
  logic signed [16:0] add_right;
  logic [CW:0] idx_p1;

  always_comb begin
    m_new  = srsu_pkg::span_merge(rdata_r.x, rdata_r.len, in_x_r, {1'b0, in_len_r});
    m_fold = srsu_pkg::span_merge(cur_x_r, cur_len_r, rdata_r.x, rdata_r.len);
    qx = {in_x_r[15], in_x_r};
    qy = {in_y_r[15], in_y_r};
    qx18 = {{2{in_x_r[15]}}, in_x_r};
    ex18 = {{2{rdata_r.x[15]}}, rdata_r.x};
    er18 = ex18 + {2'b00, rdata_r.len};
    add_right = qx + {2'b00, in_len_r};
    idx_p1 = {1'b0, idx_r} + 1'b1;
  end

  always_comb begin
    st.op        = op_r;
    st.idx_end   = (idx_r >= cnt_r);
    st.not_last  = (idx_p1 < {1'b0, cnt_r});
    st.full      = (cnt_r == CW'(MAX_SPANS));
    st.box_ok    = !(qx < $signed({left_r[15], left_r}) || qx > right_r ||
                     qy < $signed({top_r[15], top_r}) ||
                     qy > $signed({bottom_r[15], bottom_r}));
    st.hit_new   = (rdata_r.y == in_y_r) && m_new.hit;
    st.hit_fold  = (rdata_r.y == in_y_r) && m_fold.hit;
    st.hit_query = (rdata_r.y == in_y_r) && (qx18 >= ex18) && (qx18 < er18);
    st.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    rd_addr = cmd.rd_last ? AW'(cnt_r - 1'b1) : idx_r[AW-1:0];
    wr_addr = idx_r[AW-1:0];
    wdata = rdata_r;
    unique case (cmd.wr_sel)
      srsu_pkg::WR_APPEND: begin
        wr_addr = cnt_r[AW-1:0];
        wdata = '{x: in_x_r, y: in_y_r, len: {1'b0, in_len_r}};
      end
      srsu_pkg::WR_MOVE: begin
        wdata = rdata_r;
      end
      srsu_pkg::WR_BACK: begin
        wr_addr = base_r;
        wdata = '{x: cur_x_r, y: in_y_r, len: cur_len_r};
      end
      srsu_pkg::WR_SHIFT: begin
        wdata = '{x: rdata_r.x + in_x_r, y: rdata_r.y + in_y_r, len: rdata_r.len};
      end
      default: begin
        wdata = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r     <= in_tuser;
      in_x_r   <= in_tdata[15:0];
      in_y_r   <= in_tdata[31:16];
      in_len_r <= in_tdata[46:32];
    end
    if (cmd.cur_new) begin
      cur_x_r   <= m_new.x;
      cur_len_r <= m_new.len;
      base_r    <= idx_r[AW-1:0];
    end else if (cmd.cur_fold) begin
      cur_x_r   <= m_fold.x;
      cur_len_r <= m_fold.len;
    end
    if (cmd.out_load) begin
      out_data_r <= {4'd0, bottom_r, right_r, top_r, left_r, 9'(cnt_r), drop_r, inside_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      left_r      <= srsu_pkg::EDGE_INIT_LT;
      top_r       <= srsu_pkg::EDGE_INIT_LT;
      right_r     <= '0;
      bottom_r    <= '0;
      inside_r    <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch_in) begin
        idx_r    <= '0;
        inside_r <= 1'b0;
        drop_r   <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.inside_set) begin
        inside_r <= 1'b1;
      end
      if (cmd.drop_set) begin
        drop_r <= 1'b1;
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.box_add) begin
        if ($signed(in_x_r) < left_r) left_r <= $signed(in_x_r);
        if (add_right > right_r) right_r <= add_right;
        if ($signed(in_y_r) < top_r) top_r <= $signed(in_y_r);
        if ($signed(in_y_r) > bottom_r) bottom_r <= $signed(in_y_r);
      end else if (cmd.box_ofs) begin
        left_r   <= left_r + $signed(in_x_r);
        right_r  <= right_r + qx;
        top_r    <= top_r + $signed(in_y_r);
        bottom_r <= bottom_r + $signed(in_y_r);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### design/span_region_store_unit.sv
// Span region store: a raster region held as a table of horizontal spans.
// Input channel (in_*): one word per operation. tuser carries the operation
// (add span, query point, offset region); tdata carries x, y and span length.
// Result channel (out_*): exactly one word per input word, in order, with the
// query answer, the drop flag, the span count and the bounding box.
// Adds, offsets and queries whose point lies in the box walk the span table
// through a single-port memory with registered read data. An add refills the
// slot of each folded span by moving the last entry into it, unless the
// folded span is itself the last entry. A query stops at the first hit or
// skips the walk when the box test already fails. An offset rewrites every
// entry. Unused codes skip the walk.
// The table walk in the controller sets the rate; one word is in work at a time.
// The result sits in an output register, so the next word is accepted while a
// finished result still waits; if the receiver stalls when the next result is
// ready, the block holds in its final state until the register frees.
// Reset (rst_n low, synchronous) empties the table and sets the box to its
// initial edges; no clearing pass is needed since only counted entries are read.
module span_region_store_unit #(
  parameter int MAX_SPANS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coord_x[15:0], coord_y[31:16], span_length[46:32]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // inside_res[0], dropped[1], span_total[10:2],
                                  // box_left[26:11], box_top[42:27],
                                  // box_right[59:43], box_bottom[75:60]
);

  srsu_pkg::cmd_t  cmd;
  srsu_pkg::stat_t st;

  // Controller sequences the table walk; datapath owns memory and registers.
  srsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  srsu_datapath #(
    .MAX_SPANS (MAX_SPANS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

### design/srsu_checker.sv
module srsu_checker #(
  parameter int MAX_SPANS = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // A stalled result word stays valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // No result word right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The count never exceeds the table depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (MAX_SPANS >= 512) || (out_tdata[10:2] <= MAX_SPANS))
    else $error("span count above table depth");

  // A drop and an inside answer never appear in the same word.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("drop and inside both set");

  // Only one word is in work, so the input closes right after an accept.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready after accepting a word");

endmodule

bind span_region_store_unit srsu_checker #(
  .MAX_SPANS (MAX_SPANS)
) u_srsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/span_region_checker.sv
`timescale 1ns / 1ps

module span_region_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  output int          fail_count
);

  localparam int TABLE_DEPTH = 256;
  localparam int LEN_SAT = 65535;

  typedef struct packed {
    logic [15:0] bottom;
    logic [16:0] right;
    logic [15:0] top;
    logic [15:0] left;
    logic [8:0]  total;
    logic        dropped;
    logic        in_span;
  } region_word_t;

  int span_x [TABLE_DEPTH];
  int span_y [TABLE_DEPTH];
  int span_len [TABLE_DEPTH];
  int span_count;
  int edge_l, edge_t, edge_r, edge_b;
  region_word_t region_words_due[$];
  int mismatch_count;

  assign fail_count = mismatch_count + region_words_due.size();

  function automatic int wrap_16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic int wrap_17(int v);
    logic signed [16:0] t;
    t = v[16:0];
    return int'(t);
  endfunction

  // Widens span k by [nx, nx+nl) if the two overlap or touch and the new span reaches past an end of span k.
  function automatic bit widen_span(int k, int nx, int nl);
    int sx, sr, nr, lo, hi;
    bit hit;
    sx = span_x[k];
    sr = sx + span_len[k];
    nr = nx + nl;
    lo = sx;
    hi = sr;
    hit = 0;
    if (nx < sx && nr >= sx) begin
      lo = nx;
      hit = 1;
    end
    if (nx <= sr && nr > sr) begin
      hi = nr;
      hit = 1;
    end
    if (hit) begin
      span_x[k] = lo;
      span_len[k] = (hi - lo > LEN_SAT) ? LEN_SAT : hi - lo;
    end
    return hit;
  endfunction

  function automatic region_word_t predict_region(logic [1:0] op, int cx, int cy, int ln);
    region_word_t w;
    bit merged;
    int i, j, last;
    w = '0;
    case (op)
      srsu_pkg::OP_ADD: begin
        merged = 0;
        for (i = 0; i < span_count; i++) begin
          if (span_y[i] == cy && widen_span(i, cx, ln)) begin
            merged = 1;
            j = i + 1;
            while (j < span_count) begin
              if (span_y[j] == cy && widen_span(i, span_x[j], span_len[j])) begin
                last = span_count - 1;
                if (j < last) begin
                  span_x[j] = span_x[last];
                  span_y[j] = span_y[last];
                  span_len[j] = span_len[last];
                end
                span_count = last;
              end else begin
                j++;
              end
            end
            break;
          end
        end
        if (!merged) begin
          if (span_count < TABLE_DEPTH) begin
            span_x[span_count] = cx;
            span_y[span_count] = cy;
            span_len[span_count] = ln;
            span_count++;
          end else begin
            w.dropped = 1'b1;
          end
        end
        if (cx < edge_l) edge_l = cx;
        if (cx + ln > edge_r) edge_r = cx + ln;
        if (cy < edge_t) edge_t = cy;
        if (cy > edge_b) edge_b = cy;
      end
      srsu_pkg::OP_QUERY: begin
        if (!(cx < edge_l || cx > edge_r || cy < edge_t || cy > edge_b)) begin
          for (i = 0; i < span_count; i++) begin
            if (span_y[i] == cy && cx >= span_x[i] && cx < span_x[i] + span_len[i]) begin
              w.in_span = 1'b1;
              break;
            end
          end
        end
      end
      srsu_pkg::OP_OFFSET: begin
        for (i = 0; i < span_count; i++) begin
          span_x[i] = wrap_16(span_x[i] + cx);
          span_y[i] = wrap_16(span_y[i] + cy);
        end
        edge_l = wrap_16(edge_l + cx);
        edge_r = wrap_17(edge_r + cx);
        edge_t = wrap_16(edge_t + cy);
        edge_b = wrap_16(edge_b + cy);
      end
      default: ;
    endcase
    w.total = span_count[8:0];
    w.left = edge_l[15:0];
    w.top = edge_t[15:0];
    w.right = edge_r[16:0];
    w.bottom = edge_b[15:0];
    return w;
  endfunction

  always @(posedge clk) begin
    region_word_t exp_w, got_w;
    if (!rst_n) begin
      span_count = 0;
      edge_l = 1000;
      edge_t = 1000;
      edge_r = 0;
      edge_b = 0;
      region_words_due.delete();
      mismatch_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        region_words_due.push_back(predict_region(in_tuser,
            int'($signed(in_tdata[15:0])), int'($signed(in_tdata[31:16])),
            int'(in_tdata[46:32])));
      end
      if (out_tvalid && out_tready) begin
        got_w = out_tdata[75:0];
        if (region_words_due.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          mismatch_count++;
        end else begin
          exp_w = region_words_due.pop_front();
          if (got_w.in_span !== exp_w.in_span) begin
            $error("inside_res expected %0d got %0d", exp_w.in_span, got_w.in_span);
            mismatch_count++;
          end
          if (got_w.dropped !== exp_w.dropped) begin
            $error("dropped expected %0d got %0d", exp_w.dropped, got_w.dropped);
            mismatch_count++;
          end
          if (got_w.total !== exp_w.total) begin
            $error("span_total expected %0d got %0d", exp_w.total, got_w.total);
            mismatch_count++;
          end
          if (got_w.left !== exp_w.left) begin
            $error("box_left expected %h got %h", exp_w.left, got_w.left);
            mismatch_count++;
          end
          if (got_w.top !== exp_w.top) begin
            $error("box_top expected %h got %h", exp_w.top, got_w.top);
            mismatch_count++;
          end
          if (got_w.right !== exp_w.right) begin
            $error("box_right expected %h got %h", exp_w.right, got_w.right);
            mismatch_count++;
          end
          if (got_w.bottom !== exp_w.bottom) begin
            $error("box_bottom expected %h got %h", exp_w.bottom, got_w.bottom);
            mismatch_count++;
          end
        end
      end
    end
  end

endmodule

### tb/tb_span_region_store_unit.sv
`timescale 1ns / 1ps

// Top of the span region store bench. It makes the input words, paces the
// result side, and gives the verdict; all prediction and comparison happens
// in the checker instance that sits beside the block.
module tb_span_region_store_unit;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // coord_x[15:0], coord_y[31:16], span_length[46:32]
  logic [1:0]  in_tuser;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // inside_res[0], dropped[1], span_total[10:2],
                           // box_left[26:11], box_top[42:27],
                           // box_right[59:43], box_bottom[75:60]
  int          fail_count;
  int          words_sent;
  int          words_back;

  // The last span that was added, kept in step with offsets, so that queries
  // can be aimed at points that are likely to lie inside the region.
  logic [15:0] recent_x;
  logic [15:0] recent_y;
  logic [14:0] recent_len;

  span_region_store_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  span_region_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog allows for a full table on every word, with long folds,
  // both sides idling at their longest, and the long receiver stall.
  initial begin
    #100ms;
    $display("span_region_store_unit verification failed");
    $finish;
  end

  // Idle draw: about a third of the words go back to back, so that stretches
  // without gaps also occur.
  function automatic int idle_cycles();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Result side. Each word gets its own stall draw; once, early on, the
  // receiver holds off for a long stretch so that the block backs up and
  // stops accepting input while the sender keeps offering.
  initial begin
    int gap;
    out_tready = 1'b0;
    words_back = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = (words_back == 60) ? 3000 : idle_cycles();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      words_back++;
    end
  end

  // Offers one word and waits for it to be taken.
  task automatic send_word(logic [1:0] op, logic [15:0] cx, logic [15:0] cy,
                           logic [14:0] ln);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, ln, cy, cx};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    words_sent++;
    if (op == srsu_pkg::OP_ADD) begin
      recent_x = cx;
      recent_y = cy;
      recent_len = ln;
    end else if (op == srsu_pkg::OP_OFFSET) begin
      recent_x = recent_x + cx;
      recent_y = recent_y + cy;
    end
  endtask

  // Holds the sender until every word sent so far has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (words_back != words_sent) @(posedge clk);
  endtask

  // A query aimed near the most recent span: mostly inside, sometimes just
  // outside its ends or on a neighboring row.
  task automatic query_near();
    logic [15:0] qx, qy;
    qx = recent_x + 16'($urandom_range(0, recent_len + 1)) - 16'($urandom_range(0, 1));
    qy = recent_y + 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) - 1 : 0);
    send_word(srsu_pkg::OP_QUERY, qx, qy, 15'($urandom));
  endtask

  // Mixed traffic on a few crowded rows, where adds merge, fold and
  // duplicate, with queries and small shifts; a share of words carry fully
  // random fields so every bit of every field toggles.
  task automatic small_world(int count);
    int k, pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        send_word(srsu_pkg::OP_ADD, 16'($urandom_range(0, 80) - 40),
                  16'($urandom_range(0, 7)), 15'($urandom_range(0, 20)));
      end else if (pick < 68) begin
        query_near();
      end else if (pick < 80) begin
        send_word(srsu_pkg::OP_QUERY, 16'($urandom_range(0, 100) - 50),
                  16'($urandom_range(0, 8)), 15'($urandom));
      end else if (pick < 87) begin
        send_word(srsu_pkg::OP_OFFSET, 16'($urandom_range(0, 6) - 3),
                  16'($urandom_range(0, 2) - 1), 15'($urandom));
      end else if (pick < 90) begin
        send_word(OP_UNUSED, 16'($urandom), 16'($urandom), 15'($urandom));
      end else begin
        send_word(2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), 15'($urandom));
      end
    end
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = srsu_pkg::OP_ADD;
    words_sent = 0;
    recent_x = '0;
    recent_y = '0;
    recent_len = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Row 0 builds a span from the far left that merges to
    // the far right and saturates its length.
    send_word(srsu_pkg::OP_ADD, 16'h8000, 16'd0, 15'h7FFF);
    send_word(srsu_pkg::OP_ADD, 16'hFFFF, 16'd0, 15'h7FFF);
    send_word(srsu_pkg::OP_ADD, 16'h7FFE, 16'd0, 15'h7FFF);
    // Row 5: a zero-length span, touching on either end, a contained
    // duplicate, and an add that bridges two spans so the later one folds.
    send_word(srsu_pkg::OP_ADD, 16'd100, 16'd5, 15'd0);
    send_word(srsu_pkg::OP_ADD, 16'd100, 16'd5, 15'd10);
    send_word(srsu_pkg::OP_ADD, 16'd110, 16'd5, 15'd5);
    send_word(srsu_pkg::OP_ADD, 16'd90, 16'd5, 15'd10);
    send_word(srsu_pkg::OP_ADD, 16'd102, 16'd5, 15'd3);
    send_word(srsu_pkg::OP_ADD, 16'd130, 16'd5, 15'd5);
    send_word(srsu_pkg::OP_ADD, 16'd114, 16'd5, 15'd17);
    // Queries: inside, outside on the row, outside the box, at the extreme.
    send_word(srsu_pkg::OP_QUERY, 16'd100, 16'd5, 15'd0);
    send_word(srsu_pkg::OP_QUERY, 16'd200, 16'd5, 15'h7FFF);
    send_word(srsu_pkg::OP_QUERY, 16'hEC78, 16'hEC78, 15'd0);
    send_word(srsu_pkg::OP_QUERY, 16'h7FFF, 16'h7FFF, 15'd0);
    // Shifts that wrap the box and the entries, then an unused code.
    send_word(srsu_pkg::OP_OFFSET, 16'h7FFF, 16'h8000, 15'd0);
    send_word(srsu_pkg::OP_OFFSET, 16'd1, 16'd1, 15'd0);
    send_word(srsu_pkg::OP_QUERY, 16'd100, 16'h8006, 15'd0);
    send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    send_word(srsu_pkg::OP_ADD, 16'h7FFF, 16'h8000, 15'h7FFF);
    send_word(srsu_pkg::OP_QUERY, 16'd0, 16'd0, 15'd0);
    send_word(srsu_pkg::OP_OFFSET, 16'h8000, 16'h7FFF, 15'h7FFF);

    // Random part, first on a nearly empty table, including the long
    // receiver stall; then a pause until every result is back.
    small_world(180);
    drain();

    // Fill the table with spans on distinct rows until adds are dropped;
    // queries and shifts in between exercise the full-table walk.
    for (k = 0; k < 300; k++) begin
      if ($urandom_range(0, 9) == 0) query_near();
      else if ($urandom_range(0, 40) == 0)
        send_word(srsu_pkg::OP_OFFSET, 16'($urandom), 16'($urandom_range(0, 4) - 2),
                  15'($urandom));
      else
        send_word(srsu_pkg::OP_ADD, 16'($urandom), 16'(2000 + k * 3), 15'($urandom));
    end

    // Mixed traffic against a full or nearly full table, where merges free
    // slots and later appends refill them.
    small_world(450);

    // Wait for the last result, then give the block a little longer in case
    // something stray follows.
    drain();
    repeat (1000) @(posedge clk);
    if (fail_count == 0) begin
      $display("span_region_store_unit verification clean");
    end else begin
      $display("span_region_store_unit verification failed");
    end
    $finish;
  end

endmodule
